[rtl/ftr_pkg.sv]
// Shared types, widths and constants of the fan tachometer.
package ftr_pkg;

  localparam int unsigned TsW      = 63;  // timestamp width
  localparam int unsigned TpmW     = 20;  // ticks per millisecond
  localparam int unsigned EprW     = 4;   // edges per revolution
  localparam int unsigned AccW     = 32;  // accumulator width
  localparam int unsigned RpmW     = 32;  // speed width
  localparam int unsigned NumW     = 48;  // 60000 * edge total
  localparam int unsigned DenW     = 36;  // ms total * edges per revolution
  localparam int unsigned DivNW    = 63;  // divider dividend / quotient width
  localparam int unsigned DivDW    = 36;  // divider divisor width
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  localparam logic [15:0]     MsPerMinute   = 16'd60000;
  localparam logic [TpmW-1:0] TpmReset      = TpmW'(10);
  localparam logic [EprW-1:0] EprReset      = EprW'(2);
  localparam int unsigned     QueueDepthDef = 2;
  localparam logic            ModeReport    = 1'b1;

  typedef enum logic {
    KIND_EDGE   = 1'b0,
    KIND_REPORT = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TICKS_PER_MS  = 2'd0,
    REG_EDGES_PER_REV = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    kind_e          kind;
    logic [TsW-1:0] ts;
  } cmd_t;

  typedef struct packed {
    logic [TpmW-1:0] tpm;
    logic [EprW-1:0] epr;
  } cfg_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] dividend;
    logic [DivDW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DivNW-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/ftr_front.sv]
// Front end: accept input transfers, classify them and queue them for the back end.
module ftr_front import ftr_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           mode_i,
  input  logic [TsW-1:0] timestamp_ticks_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output cmd_t           cmd_o,
  output q_stat_t        stat_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;
  cmd_t            in_cmd;

  // Classify: mode bit selects edge or report.
  assign in_cmd.kind = (mode_i == ModeReport) ? KIND_REPORT : KIND_EDGE;
  assign in_cmd.ts   = timestamp_ticks_i;

  assign in_ready_o  = (count_q != FullCnt);
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == FullCnt);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

[rtl/ftr_div.sv]
// Restoring bit-serial divider, one quotient bit per cycle.
module ftr_div import ftr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DivNW + 1);

  logic             busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DivDW-1:0] rem_q, rem_d, dsr_q, dsr_d;
  logic [DivNW-1:0] quo_q, quo_d;
  logic [DivDW:0]   shifted;
  logic [DivDW+1:0] trial;
  logic             ge;

  assign shifted = {rem_q, quo_q[DivNW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr_q};
  assign ge      = !trial[DivDW+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivNW);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? trial[DivDW-1:0] : shifted[DivDW-1:0];
      quo_d = {quo_q[DivNW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[rtl/ftr_back.sv]
// Back end: edge accumulation, report computation and the output register.
module ftr_back import ftr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  cmd_t            cmd_i,
  output div_req_t        div_req_o,
  input  div_rsp_t        div_rsp_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [RpmW-1:0] speed_rpm_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_e;

  state_e           state_q, state_d;
  kind_e            op_q, op_d;
  logic             seen_q, seen_d;
  logic [TsW-1:0]   last_q, last_d;
  logic [AccW-1:0]  ms_total_q, ms_total_d, edge_total_q, edge_total_d;
  logic             out_valid_q, out_valid_d;
  logic [RpmW-1:0]  speed_q, speed_d;

  logic [TpmW-1:0]  tpm_eff;
  logic [EprW-1:0]  epr_eff;
  logic             totals_nz, pop;
  logic [TsW-1:0]   ts_diff;
  logic [NumW-1:0]  num;
  logic [DenW-1:0]  den;
  logic [AccW:0]    ms_sum;
  logic [AccW-1:0]  ms_sat, edge_sat;
  logic [RpmW-1:0]  speed_sat;

  assign tpm_eff   = (cfg_i.tpm == '0) ? TpmW'(1) : cfg_i.tpm;
  assign epr_eff   = (cfg_i.epr == '0) ? EprW'(1) : cfg_i.epr;
  assign totals_nz = (ms_total_q != '0) && (edge_total_q != '0);

  // Reports need a free output register; edges never produce a result.
  assign cmd_ready_o = (state_q == ST_IDLE) && ((cmd_i.kind == KIND_EDGE) || !out_valid_q);
  assign pop         = cmd_valid_i && cmd_ready_o;

  assign ts_diff = cmd_i.ts - last_q;
  assign num     = NumW'(MsPerMinute) * NumW'(edge_total_q);
  assign den     = DenW'(ms_total_q) * DenW'(epr_eff);

  always_comb begin
    div_req_o.start    = 1'b0;
    div_req_o.dividend = ts_diff;
    div_req_o.divisor  = DivDW'(tpm_eff);
    if (pop && (cmd_i.kind == KIND_EDGE) && seen_q) begin
      div_req_o.start = 1'b1;
    end else if (pop && (cmd_i.kind == KIND_REPORT) && totals_nz) begin
      div_req_o.start    = 1'b1;
      div_req_o.dividend = DivNW'(num);
      div_req_o.divisor  = den;
    end
  end

  assign ms_sum    = {1'b0, ms_total_q} + {1'b0, div_rsp_i.quotient[AccW-1:0]};
  assign ms_sat    = ((|div_rsp_i.quotient[DivNW-1:AccW]) || ms_sum[AccW]) ? '1
                                                                           : ms_sum[AccW-1:0];
  assign edge_sat  = (&edge_total_q) ? edge_total_q : edge_total_q + 1'b1;
  assign speed_sat = (|div_rsp_i.quotient[DivNW-1:RpmW]) ? '1 : div_rsp_i.quotient[RpmW-1:0];

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    seen_d       = seen_q;
    last_d       = last_q;
    ms_total_d   = ms_total_q;
    edge_total_d = edge_total_q;
    out_valid_d  = out_valid_q;
    speed_d      = speed_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          if (cmd_i.kind == KIND_EDGE) begin
            seen_d = 1'b1;
            last_d = cmd_i.ts;
            if (seen_q) begin
              op_d    = KIND_EDGE;
              state_d = ST_DIV;
            end
          end else if (totals_nz) begin
            op_d    = KIND_REPORT;
            state_d = ST_DIV;
          end else begin
            out_valid_d = 1'b1;
            speed_d     = '0;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp_i.done) begin
          state_d = ST_IDLE;
          if (op_q == KIND_EDGE) begin
            ms_total_d   = ms_sat;
            edge_total_d = edge_sat;
          end else begin
            out_valid_d  = 1'b1;
            speed_d      = speed_sat;
            ms_total_d   = '0;
            edge_total_d = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= KIND_EDGE;
      seen_q       <= 1'b0;
      last_q       <= '0;
      ms_total_q   <= '0;
      edge_total_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      seen_q       <= seen_d;
      last_q       <= last_d;
      ms_total_q   <= ms_total_d;
      edge_total_q <= edge_total_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    speed_q <= speed_d;
  end

  assign out_valid_o = out_valid_q;
  assign speed_rpm_o = speed_q;

endmodule

[rtl/fan_tachometer_rpm.sv]
// Top level of the fan tachometer: configuration registers, front end, back end, divider.
// Fan tachometer that averages the tach period. Each input transfer is either a rising edge
// of the tach pin (mode 0, with a 63-bit tick timestamp) or the end of a report window
// (mode 1). The first edge after reset only records its timestamp; every later edge adds
// the whole milliseconds since the previous edge (tick difference modulo 2^63 divided by
// ticks_per_ms, floored) to a saturating 32-bit total and counts one edge. A report with
// both totals nonzero returns floor(60000*edges / (ms*edges_per_revolution)) saturated to
// 32 bits and clears both totals; otherwise it returns 0 and leaves the totals alone. Edges
// return nothing. A zero in either configuration register acts as 1. An edge that closes
// an interval and a report with data each occupy the back end for a dispatch step, one
// iteration of the shared bit-serial divider per bit of the 63-bit quotient at one
// quotient bit per cycle, and a retire step; the first edge and a report without data
// are handled in the dispatch step alone. The divider sets the sustained rate. A queue of
// QueueDepth entries sits between the input and the back end, so while it has room the
// input keeps taking transfers while a division runs or a result waits in the output
// register. The configuration port is always ready; write it only while the block is idle.
module fan_tachometer_rpm import ftr_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic [TsW-1:0]      timestamp_ticks_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [RpmW-1:0]     speed_rpm_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [TpmW-1:0] tpm_q;
  logic [EprW-1:0] epr_q;
  cfg_t            cfg;
  logic            cmd_valid, cmd_ready;
  cmd_t            cmd;
  q_stat_t         q_stat;
  div_req_t        div_req;
  div_rsp_t        div_rsp;

  // Configuration writes go straight into the registers; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q <= TpmReset;
      epr_q <= EprReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_TICKS_PER_MS:  tpm_q <= cfg_data_i[TpmW-1:0];
        REG_EDGES_PER_REV: epr_q <= cfg_data_i[EprW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.tpm = tpm_q;
  assign cfg.epr = epr_q;

  // Front end: take transfers and hold them until the back end is free.
  ftr_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .mode_i,
    .timestamp_ticks_i,
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd),
    .stat_o      (q_stat)
  );

  // Back end: tach state, the report math and the output register.
  ftr_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o,
    .out_ready_i,
    .speed_rpm_o
  );

  // One divider serves both the interval and the speed division.
  ftr_div u_div (
    .clk_i,
    .rst_ni,
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // An accepted transfer lands in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !q_stat.empty)
    else $error("accepted transfer missing from queue");

  // Never restart the divider while it iterates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // A quotient is only flagged right after the last iteration.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> $past(div_rsp.busy))
    else $error("divider done without prior iteration");

  // The queue never reports full and empty together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.empty && q_stat.full))
    else $error("queue full and empty at once");

endmodule
